FILE: rtl/core/day_number_to_civil_date_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the day number to civil date unit
// Shared property forms; the asserting module supplies clk and rst.
// ----------------------------------------------------------------------------
`ifndef DAY_NUMBER_TO_CIVIL_DATE_UNIT_ASSERT_SVH
`define DAY_NUMBER_TO_CIVIL_DATE_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define DNCD_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds after ante, at the delay that n gives.
`define DNCD_CHECK_LATER(label, n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dncd_pkg.sv
// ----------------------------------------------------------------------------
// dncd_pkg
// Constants, tables, helpers and stage types for the day-to-date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dncd_pkg;

  localparam int DAY_W   = 23;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int N_W     = 22;  // days since 0001-01-01
  localparam int OFF_W   = 9;   // day offset within a year
  localparam int CENT_W  = 7;   // year / 100
  localparam int RECIP_W = 24;
  localparam int CRECIP_W = 13;

  localparam int PIPE_DEPTH = 7;

  localparam logic signed [DAY_W-1:0] DAY_MIN = -23'sd719162;
  localparam logic signed [DAY_W-1:0] DAY_MAX = 23'sd2932896;
  localparam logic signed [DAY_W:0]   EPOCH_SHIFT = 24'sd719162;
  localparam logic [N_W-1:0]          N_MAX = 22'd3652058;

  // Year estimate: n * YEAR_RECIP >> YEAR_SHIFT, just under n / 365.2425.
  localparam logic [RECIP_W-1:0] YEAR_RECIP = 24'd11759221;
  localparam int                 YEAR_SHIFT = 32;

  // Century: y * CENT_RECIP >> CENT_SHIFT equals y / 100 for y up to 10000.
  localparam logic [CRECIP_W-1:0] CENT_RECIP = 13'd5243;
  localparam int                  CENT_SHIFT = 19;

  localparam logic [OFF_W-1:0] DAYS_PER_YEAR = 9'd365;

  // Month codes used by the month stage.
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

  function automatic logic [OFF_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [OFF_W-1:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CENT_W-1:0] cent_of(input logic [YEAR_W-1:0] y);
    logic [YEAR_W+CRECIP_W-1:0] p;
    p = {{CRECIP_W{1'b0}}, y} * {{YEAR_W{1'b0}}, CENT_RECIP};
    return p[CENT_SHIFT +: CENT_W];
  endfunction

  // Days from 0001-01-01 to 1 January of year y+1, with q = y / 100.
  function automatic logic [N_W-1:0] first_of(input logic [YEAR_W-1:0] y,
                                               input logic [CENT_W-1:0] q);
    logic [N_W:0] t;
    t = (N_W+1)'(y) * (N_W+1)'(DAYS_PER_YEAR) + (N_W+1)'(y >> 2)
        - (N_W+1)'(q) + (N_W+1)'(q >> 2);
    return t[N_W-1:0];
  endfunction

  typedef struct packed {
    logic              valid;
    logic [N_W-1:0]    n;
    logic [YEAR_W-1:0] ye;
    logic [CENT_W-1:0] q0;
    logic [CENT_W-1:0] q1;
    logic [CENT_W-1:0] q2;
  } est_t;

  typedef struct packed {
    logic              valid;
    logic [YEAR_W-1:0] year;
    logic [OFF_W-1:0]  off;
    logic              leap;
  } yr_t;

endpackage

FILE: rtl/core/day_number_to_civil_date_unit.sv
// Each accepted item gives its result on the outputs with strobe.
// Throughput: one item per cycle; the seven-stage pipeline never stalls.
// busy follows rst, so items are refused only while reset is held.
// Reset (synchronous, rst high) clears every stage valid bit; items in flight
// are dropped and give no result.
// ----------------------------------------------------------------------------
// day_number_to_civil_date_unit
// Converts signed days since 1970-01-01 into proleptic Gregorian year,
// month and day of month, over years 1 to 9999 (inputs outside saturate).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module day_number_to_civil_date_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [dncd_pkg::DAY_W-1:0]   day_count,
  output logic                                busy,
  output logic                                strobe,
  output logic [dncd_pkg::YEAR_W-1:0]         year,
  output logic [dncd_pkg::MONTH_W-1:0]        month,
  output logic [dncd_pkg::DOM_W-1:0]          day_of_month
);

  logic           take;
  dncd_pkg::est_t est;
  dncd_pkg::yr_t  yr;

  // The pipeline advances every cycle and the receiver cannot hold results
  // off, so there is never back-pressure: refuse items only during reset.
  assign busy = rst;
  assign take = start & ~busy;

  // Stages 1-3: saturate the input, rebase to 0001-01-01, estimate the whole years
  // elapsed with a reciprocal multiply (never above the true count, at most one
  // below) and compute the century counts of the estimate and the next two years.
  dncd_year_est u_est (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .day_count (day_count),
    .est       (est)
  );

  // Stages 4-5: day numbers of 1 January for the two candidate years, one
  // compare to settle the year, then the offset within the year and its
  // leap flag.
  dncd_year_fix u_fix (
    .clk (clk),
    .rst (rst),
    .est (est),
    .yr  (yr)
  );

  // Stages 6-7: month from the cumulative-days table with the leap day from
  // March onward, then the day of month; outputs are registered with strobe.
  dncd_month u_month (
    .clk          (clk),
    .rst          (rst),
    .yr           (yr),
    .strobe       (strobe),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month)
  );

endmodule

FILE: rtl/core/dncd_year_est.sv
// ----------------------------------------------------------------------------
// dncd_year_est
// Clamp, rebase to 0001-01-01, estimate the year and its century counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dncd_year_est (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic signed [dncd_pkg::DAY_W-1:0]   day_count,
  output dncd_pkg::est_t                      est
);

  localparam int PW = dncd_pkg::N_W + dncd_pkg::RECIP_W;

  logic                            v1;
  logic [dncd_pkg::N_W-1:0]        n1;
  logic [dncd_pkg::N_W-1:0]        n1_next;
  logic signed [dncd_pkg::DAY_W:0] shifted;

  logic                            v2;
  logic [dncd_pkg::N_W-1:0]        n2;
  logic [dncd_pkg::YEAR_W-1:0]     ye2;
  logic [PW-1:0]                   prod;

  // Stage 1: saturate and rebase.
  always_comb begin
    shifted = {day_count[dncd_pkg::DAY_W-1], day_count} + dncd_pkg::EPOCH_SHIFT;
    if (day_count < dncd_pkg::DAY_MIN) begin
      n1_next = '0;
    end else if (day_count > dncd_pkg::DAY_MAX) begin
      n1_next = dncd_pkg::N_MAX;
    end else begin
      n1_next = shifted[dncd_pkg::N_W-1:0];
    end
  end

  // Stage 2: reciprocal multiply for the year estimate.
  assign prod = {{dncd_pkg::RECIP_W{1'b0}}, n1} * {{dncd_pkg::N_W{1'b0}}, dncd_pkg::YEAR_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      est.valid <= 1'b0;
    end else begin
      v1        <= take;
      v2        <= v1;
      est.valid <= v2;
    end
    n1     <= n1_next;
    n2     <= n1;
    ye2    <= prod[dncd_pkg::YEAR_SHIFT +: dncd_pkg::YEAR_W];
    // Stage 3: century counts of the estimate and the next two years.
    est.n  <= n2;
    est.ye <= ye2;
    est.q0 <= dncd_pkg::cent_of(ye2);
    est.q1 <= dncd_pkg::cent_of(ye2 + 14'd1);
    est.q2 <= dncd_pkg::cent_of(ye2 + 14'd2);
  end

endmodule

FILE: rtl/core/dncd_year_fix.sv
// ----------------------------------------------------------------------------
// dncd_year_fix
// Correct the year estimate by one and find the day offset within the year.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dncd_year_fix (
  input  logic           clk,
  input  logic           rst,
  input  dncd_pkg::est_t est,
  output dncd_pkg::yr_t  yr
);

  logic                        v4;
  logic [dncd_pkg::N_W-1:0]    n4;
  logic [dncd_pkg::YEAR_W-1:0] ye4;
  logic [dncd_pkg::N_W-1:0]    fa;
  logic [dncd_pkg::N_W-1:0]    fb;
  logic                        leap1;
  logic                        leap2;
  logic                        leap1_next;
  logic                        leap2_next;
  logic [dncd_pkg::YEAR_W-1:0] y1;
  logic [dncd_pkg::YEAR_W-1:0] y2;

  logic                        sel;
  logic [dncd_pkg::N_W-1:0]    diff;

  // Stage 4: leap flags of the two candidate years. A year that starts a new
  // century count is a century year and is leap only when that count is a
  // multiple of four.
  always_comb begin
    y1 = est.ye + 14'd1;
    y2 = est.ye + 14'd2;
    leap1_next = (y1[1:0] == 2'd0) && ((est.q1 == est.q0) || (est.q1[1:0] == 2'd0));
    leap2_next = (y2[1:0] == 2'd0) && ((est.q2 == est.q1) || (est.q2[1:0] == 2'd0));
  end

  // Stage 5: pick the year and take the offset.
  always_comb begin
    sel  = (n4 >= fb);
    diff = n4 - (sel ? fb : fa);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4       <= 1'b0;
      yr.valid <= 1'b0;
    end else begin
      v4       <= est.valid;
      yr.valid <= v4;
    end
    n4      <= est.n;
    ye4     <= est.ye;
    fa      <= dncd_pkg::first_of(est.ye, est.q0);
    fb      <= dncd_pkg::first_of(y1, est.q1);
    leap1   <= leap1_next;
    leap2   <= leap2_next;
    yr.year <= ye4 + 14'd1 + 14'(sel);
    yr.off  <= diff[dncd_pkg::OFF_W-1:0];
    yr.leap <= sel ? leap2 : leap1;
  end

endmodule

FILE: rtl/core/dncd_month.sv
// ----------------------------------------------------------------------------
// dncd_month
// Split the day offset into month and day of month, leap day included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dncd_month (
  input  logic                           clk,
  input  logic                           rst,
  input  dncd_pkg::yr_t                  yr,
  output logic                           strobe,
  output logic [dncd_pkg::YEAR_W-1:0]    year,
  output logic [dncd_pkg::MONTH_W-1:0]   month,
  output logic [dncd_pkg::DOM_W-1:0]     day_of_month
);

  logic                         v6;
  logic [dncd_pkg::MONTH_W-1:0] m6;
  logic [dncd_pkg::MONTH_W-1:0] m6_next;
  logic [dncd_pkg::OFF_W-1:0]   off6;
  logic                         leap6;
  logic [dncd_pkg::YEAR_W-1:0]  year6;
  logic [dncd_pkg::OFF_W-1:0]   base;
  logic [dncd_pkg::OFF_W-1:0]   dom;

  // Stage 6: count the month starts at or below the offset.
  always_comb begin
    m6_next = dncd_pkg::MONTH_JAN;
    for (int k = 1; k <= 11; k++) begin
      if (yr.off >= dncd_pkg::cum_days(4'(k)) +
          9'((4'(k) >= dncd_pkg::MONTH_MAR) && yr.leap)) begin
        m6_next = m6_next + 4'd1;
      end
    end
  end

  // Stage 7: day within the month.
  always_comb begin
    base = dncd_pkg::cum_days(m6) + 9'((m6 >= dncd_pkg::MONTH_MAR) && leap6);
    dom  = off6 - base + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      v6     <= yr.valid;
      strobe <= v6;
    end
  end

  always_ff @(posedge clk) begin
    m6           <= m6_next;
    off6         <= yr.off;
    leap6        <= yr.leap;
    year6        <= yr.year;
    year         <= year6;
    month        <= m6 + 4'd1;
    day_of_month <= dom[dncd_pkg::DOM_W-1:0];
  end

endmodule

FILE: rtl/core/dncd_checker.sv
// ----------------------------------------------------------------------------
// dncd_checker
// Port-level checks on timing, result ranges and low saturation of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "day_number_to_civil_date_unit_assert.svh"

module dncd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic signed [dncd_pkg::DAY_W-1:0]   day_count,
  input logic                                busy,
  input logic                                strobe,
  input logic [dncd_pkg::YEAR_W-1:0]         year,
  input logic [dncd_pkg::MONTH_W-1:0]        month,
  input logic [dncd_pkg::DOM_W-1:0]          day_of_month
);

  logic take;
  assign take = start && !busy;

  `DNCD_CHECK_LATER(a_result_follows, dncd_pkg::PIPE_DEPTH, take, strobe, "item gave no result")
  `DNCD_CHECK_LATER(a_no_phantom, dncd_pkg::PIPE_DEPTH, !take, !strobe, "result without an item")
  `DNCD_CHECK_NOW(a_ranges, strobe, year >= 14'd1 && year <= 14'd9999 && month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 && day_of_month <= 5'd31, "result field out of range")
  `DNCD_CHECK_LATER(a_floor, dncd_pkg::PIPE_DEPTH, take && day_count <= dncd_pkg::DAY_MIN, year == 14'd1 && month == 4'd1 && day_of_month == 5'd1, "low saturation wrong")

endmodule

bind day_number_to_civil_date_unit dncd_checker u_dncd_checker (.*);
